/* src/linear_probe_key_value_table_macros.svh */
// Assertion macros shared by the checker of the key/value table
`ifndef LINEAR_PROBE_KEY_VALUE_TABLE_MACROS_SVH
`define LINEAR_PROBE_KEY_VALUE_TABLE_MACROS_SVH

// Antecedent implies consequent in the same cycle
`define LPKV_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent implies consequent in the next cycle
`define LPKV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/lpkv_pkg.sv */
// Types and constants of the linear-probing key/value table
package lpkv_pkg;

	localparam int KEY_IN_W   = 32;
	localparam int VAL_IN_W   = 32;
	localparam int CNT_W      = 11;
	localparam int S_TDATA_W  = 64;
	localparam int S_TUSER_W  = 2;
	localparam int M_TDATA_W  = 48;
	localparam int M_TUSER_W  = 3;
	localparam int MARK_W     = 2;

	localparam logic [CNT_W-1:0] LIMIT_RESET = 11'd768;

	localparam logic [MARK_W-1:0] MARK_EMPTY = 2'd0;
	localparam logic [MARK_W-1:0] MARK_LIVE  = 2'd1;
	localparam logic [MARK_W-1:0] MARK_TOMB  = 2'd2;

	typedef enum logic [1:0] {
		OP_LOOKUP = 2'd0,
		OP_INSERT = 2'd1,
		OP_DELETE = 2'd2,
		OP_CLEAR  = 2'd3
	} lpkv_op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2
	} lpkv_status_t;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_HOME,
		S_CHECK,
		S_CLEAR,
		S_FINISH
	} lpkv_state_t;

	typedef struct packed {
		logic load;
		logic home_step;
		logic probe_start;
		logic probe_check;
		logic sweep_start;
		logic sweep;
		logic finish;
	} lpkv_cmd_t;

	typedef struct packed {
		logic is_clear;
		logic home_done;
		logic probe_end;
		logic sweep_last;
	} lpkv_sts_t;

endpackage

/* src/linear_probe_key_value_table.sv */
// Top level of the linear-probing key/value table
//
// Input stream s_*: one operation per transaction; tuser carries the opcode
// (lookup, insert or update, delete, clear), tdata the key and the value.
// Output stream m_*: exactly one result per operation, in order; tuser carries
// status and found, tdata the read value and the live entry count.
// cfg_*: writes the entry limit (default 768); write only while the block is idle.
// Operations are handled one at a time. A lookup, insert or delete probes
// slots one per cycle through the single read port of the slot memory. The
// next operation can be accepted in the cycle the result first shows. A
// table size that is not a power of two adds a three-step remainder for the
// home slot. Clear sweeps the memory.
// After reset the same sweep empties every slot before the first operation
// is taken. A result waits in the output register while the receiver
// stalls; the next operation is still accepted and runs until it has its
// own result ready, then holds.
module linear_probe_key_value_table import lpkv_pkg::*; #(
	parameter int SLOTS      = 1024,
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // key[31:0], value[63:32]
	input  logic [S_TUSER_W-1:0] s_tuser,   // opcode[1:0]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,   // read_value[31:0], live_count[42:32], zero[47:43]
	output logic [M_TUSER_W-1:0] m_tuser,   // status[1:0], found[2]
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CNT_W-1:0]     cfg_data
);

	lpkv_cmd_t cmd;
	lpkv_sts_t sts;

	assign cfg_ready = 1'b1;

	lpkv_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lpkv_datapath #(
		.SLOTS      (SLOTS),
		.KEY_BITS   (KEY_BITS),
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

/* src/lpkv_ctrl.sv */
// Operation sequencer of the key/value table
module lpkv_ctrl import lpkv_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	output logic      m_tvalid,
	input  logic      m_tready,
	input  lpkv_sts_t sts,
	output lpkv_cmd_t cmd
);

	lpkv_state_t state_q, state_d;
	logic        out_valid_q;
	logic        out_free;

	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_INIT: begin
				if (sts.sweep_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (s_tvalid) state_d = S_HOME;
			end
			S_HOME: begin
				if (sts.is_clear) state_d = S_CLEAR;
				else if (sts.home_done) state_d = S_CHECK;
			end
			S_CHECK: begin
				if (sts.probe_end) state_d = S_FINISH;
			end
			S_CLEAR: begin
				if (sts.sweep_last) state_d = S_FINISH;
			end
			S_FINISH: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_INIT;
		endcase
	end

	always_comb begin
		cmd = '0;
		s_tready = 1'b0;
		case (state_q)
			S_INIT: begin
				cmd.sweep = 1'b1;
			end
			S_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			S_HOME: begin
				if (sts.is_clear) cmd.sweep_start = 1'b1;
				else if (sts.home_done) cmd.probe_start = 1'b1;
				else cmd.home_step = 1'b1;
			end
			S_CHECK: begin
				cmd.probe_check = 1'b1;
			end
			S_CLEAR: begin
				cmd.sweep = 1'b1;
			end
			S_FINISH: begin
				cmd.finish = out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// a fresh result takes priority over the drain of the old one
			if (cmd.finish) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;

endmodule

/* src/lpkv_datapath.sv */
// Slot memory, probe datapath, entry count and result register of the key/value table
module lpkv_datapath import lpkv_pkg::*; #(
	parameter int SLOTS      = 1024,
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [S_TDATA_W-1:0] s_tdata,
	input  logic [S_TUSER_W-1:0] s_tuser,
	input  logic                 cfg_valid,
	input  logic [CNT_W-1:0]     cfg_data,
	input  lpkv_cmd_t            cmd,
	output lpkv_sts_t            sts,
	output logic [M_TDATA_W-1:0] m_tdata,
	output logic [M_TUSER_W-1:0] m_tuser
);

	localparam int AW = $clog2(SLOTS);
	localparam int KW = (KEY_BITS < KEY_IN_W) ? KEY_BITS : KEY_IN_W;
	localparam int VW = (VALUE_BITS < VAL_IN_W) ? VALUE_BITS : VAL_IN_W;
	localparam int RW = MARK_W + KW + VW;
	localparam logic [AW-1:0] LAST = AW'(SLOTS - 1);
	localparam bit POW2 = (SLOTS == (1 << AW));

	logic [RW-1:0]    mem_q [SLOTS];
	logic [RW-1:0]    rdata_q;
	logic [AW-1:0]    raddr;
	logic             we;
	logic [AW-1:0]    waddr;
	logic [MARK_W-1:0] wmark;

	lpkv_op_t         op_q;
	logic [KW-1:0]    key_q;
	logic [VW-1:0]    val_q;
	logic [AW-1:0]    idx_q, idx_next;
	logic [AW-1:0]    n_q;
	logic [AW-1:0]    free_q;
	logic             hit_q, have_free_q;
	logic [CNT_W-1:0] cnt_q, cnt_d, limit_q;

	logic [AW-1:0]    home;
	logic             home_done;

	logic [MARK_W-1:0] rd_mark;
	logic [KW-1:0]    rd_key;
	logic [VW-1:0]    rd_val;
	logic             is_empty, is_live, match, probe_end;

	lpkv_status_t     res_status;
	logic             res_found;
	logic [VW-1:0]    res_val;

	lpkv_status_t     status_q;
	logic             found_q;
	logic [VAL_IN_W-1:0] rdval_q;
	logic [CNT_W-1:0] live_q;

	// Home slot: low key bits for a power-of-two table, otherwise a three-step remainder
	generate
		if (POW2) begin : g_mask
			assign home      = AW'(key_q);
			assign home_done = 1'b1;
		end else begin : g_rem
			// estimate the quotient by a reciprocal, so the remainder is off by at most one SLOTS
			localparam logic [KW-1:0] RECIP = KW'((64'd1 << KW) / 64'(SLOTS));
			logic [2*KW-1:0] prod_q;
			logic [KW-1:0]   rem_q;
			logic [AW-1:0]   home_q;
			logic [1:0]      step_q;
			logic [KW-1:0]   quot;

			assign quot = prod_q[2*KW-1 -: KW];

			always_ff @(posedge clk) begin
				if (cmd.load) begin
					step_q <= '0;
				end else if (cmd.home_step) begin
					case (step_q)
						2'd0: prod_q <= {{KW{1'b0}}, key_q} * {{KW{1'b0}}, RECIP};
						2'd1: rem_q <= key_q - quot * KW'(SLOTS);
						default: begin
							if (64'(rem_q) >= 64'(SLOTS)) home_q <= AW'(64'(rem_q) - 64'(SLOTS));
							else home_q <= AW'(rem_q);
						end
					endcase
					step_q <= step_q + 1'b1;
				end
			end

			assign home      = home_q;
			assign home_done = (step_q == 2'd3);
		end
	endgenerate

	assign rd_mark  = rdata_q[RW-1 -: MARK_W];
	assign rd_key   = rdata_q[VW +: KW];
	assign rd_val   = rdata_q[VW-1:0];
	assign is_empty = (rd_mark == MARK_EMPTY);
	assign is_live  = (rd_mark == MARK_LIVE);
	assign match    = is_live && (rd_key == key_q);
	assign probe_end = is_empty || match || (n_q == LAST);
	assign idx_next = (idx_q == LAST) ? '0 : idx_q + 1'b1;

	assign sts.is_clear   = (op_q == OP_CLEAR);
	assign sts.home_done  = home_done;
	assign sts.probe_end  = probe_end;
	assign sts.sweep_last = (idx_q == LAST);

	// Present the next slot to the memory while this one is checked
	always_comb begin
		if (cmd.probe_start) raddr = home;
		else if (cmd.probe_check && !probe_end) raddr = idx_next;
		else raddr = idx_q;
	end

	always_comb begin
		we         = 1'b0;
		waddr      = idx_q;
		wmark      = MARK_EMPTY;
		res_status = ST_OK;
		res_found  = 1'b0;
		res_val    = '0;
		cnt_d      = cnt_q;
		if (cmd.sweep) begin
			we = 1'b1;
		end else if (cmd.finish) begin
			case (op_q)
				OP_LOOKUP: begin
					if (hit_q) begin
						res_found = 1'b1;
						res_val   = rd_val;
					end else begin
						res_status = ST_NOT_FOUND;
					end
				end
				OP_INSERT: begin
					if (hit_q) begin
						res_found = 1'b1;
						we        = 1'b1;
						wmark     = MARK_LIVE;
					end else if (cnt_q >= limit_q || !have_free_q) begin
						res_status = ST_FULL;
					end else begin
						we    = 1'b1;
						waddr = free_q;
						wmark = MARK_LIVE;
						cnt_d = cnt_q + 1'b1;
					end
				end
				OP_DELETE: begin
					if (hit_q) begin
						res_found = 1'b1;
						we        = 1'b1;
						wmark     = MARK_TOMB;
						cnt_d     = cnt_q - 1'b1;
					end else begin
						res_status = ST_NOT_FOUND;
					end
				end
				OP_CLEAR: begin
					cnt_d = '0;
				end
				default: begin
					cnt_d = cnt_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= {wmark, key_q, val_q};
		rdata_q <= mem_q[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			cnt_q   <= '0;
			limit_q <= LIMIT_RESET;
		end else begin
			if (cmd.probe_start) idx_q <= home;
			else if (cmd.probe_check && !probe_end) idx_q <= idx_next;
			else if (cmd.sweep_start) idx_q <= '0;
			else if (cmd.sweep) idx_q <= idx_next;
			if (cmd.finish) cnt_q <= cnt_d;
			if (cfg_valid) limit_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= lpkv_op_t'(s_tuser);
			key_q <= s_tdata[KW-1:0];
			val_q <= s_tdata[KEY_IN_W +: VW];
		end
		if (cmd.probe_start) begin
			hit_q       <= 1'b0;
			have_free_q <= 1'b0;
			n_q         <= '0;
		end else if (cmd.probe_check) begin
			if (match) hit_q <= 1'b1;
			// remember the first reusable slot: a tombstone or the empty slot that ends the chain
			if (!have_free_q && !is_live) begin
				have_free_q <= 1'b1;
				free_q      <= idx_q;
			end
			if (!probe_end) n_q <= n_q + 1'b1;
		end
		if (cmd.finish) begin
			status_q <= res_status;
			found_q  <= res_found;
			rdval_q  <= VAL_IN_W'(res_val);
			live_q   <= cnt_d;
		end
	end

	assign m_tdata = {{(M_TDATA_W - VAL_IN_W - CNT_W){1'b0}}, live_q, rdval_q};
	assign m_tuser = {found_q, status_q};

endmodule

/* src/lpkv_checker.sv */
// Port-level checks of the key/value table, bound to the top level
`include "linear_probe_key_value_table_macros.svh"

module lpkv_checker import lpkv_pkg::*; #(
	parameter int SLOTS = 1024
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata,
	input logic [M_TUSER_W-1:0] m_tuser
);

	`LPKV_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
	`LPKV_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, s_tvalid && s_tready, !s_tready, "second operation taken while one is in work")
	`LPKV_ASSERT_NOW(a_status_code, clk, arst_n, m_tvalid, m_tuser[1:0] <= ST_FULL, "undefined status code")
	`LPKV_ASSERT_NOW(a_found_ok, clk, arst_n, m_tvalid && m_tuser[2], m_tuser[1:0] == ST_OK, "found with a failing status")
	`LPKV_ASSERT_NOW(a_count_bound, clk, arst_n, m_tvalid, m_tdata[42:32] <= CNT_W'(SLOTS), "live count beyond table size")

endmodule

bind linear_probe_key_value_table lpkv_checker #(.SLOTS(SLOTS)) u_lpkv_checker (.*);
